>>> design/shm_pkg.sv
// Package for the sensor health monitor: health codes, command codes,
// register indexes, reset values and a saturating increment. No dependencies.
package shm_pkg;

   typedef enum logic [1:0] {
      HEALTH_UNINIT   = 2'd0,
      HEALTH_NOMINAL  = 2'd1,
      HEALTH_DEGRADED = 2'd2,
      HEALTH_FAILED   = 2'd3
   } health_type;

   typedef enum logic [1:0] {
      CMD_RECORD  = 2'd0,
      CMD_IDLE    = 2'd1,
      CMD_BEGIN   = 2'd2,
      CMD_DEGRADE = 2'd3
   } command_type;

   typedef enum logic [2:0] {
      REG_DEGRADE_FAILURES       = 3'd0,
      REG_FAIL_FAILURES          = 3'd1,
      REG_RECOVER_SUCCESSES      = 3'd2,
      REG_FULL_RECOVER_SUCCESSES = 3'd3,
      REG_STALE_DEGRADE_TIME     = 3'd4,
      REG_STALE_FAIL_TIME        = 3'd5
   } reg_index_type;

   localparam int COUNT_W  = 8;
   localparam int TIME_W   = 32;
   localparam int ADDR_W   = 5;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 8;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   localparam logic [COUNT_W-1:0] RST_DEGRADE_FAILURES       = 8'd3;
   localparam logic [COUNT_W-1:0] RST_FAIL_FAILURES          = 8'd5;
   localparam logic [COUNT_W-1:0] RST_RECOVER_SUCCESSES      = 8'd3;
   localparam logic [COUNT_W-1:0] RST_FULL_RECOVER_SUCCESSES = 8'd10;
   localparam logic [TIME_W-1:0]  RST_STALE_DEGRADE_TIME     = 32'd0;
   localparam logic [TIME_W-1:0]  RST_STALE_FAIL_TIME        = 32'd0;

   function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] c);
      return (c == COUNT_MAX) ? c : c + COUNT_W'(1);
   endfunction

endpackage

>>> design/sensor_health_monitor.sv
// Sensor health monitor: one input register, one result register, health state.
// Depends on shm_pkg.
//
// One request in, one result out, at a sustained rate of one request per clock while
// the result side does not stall. Each request is held in the input register and then
// moves to the result register when the result side has room; the health update is a
// single pass of logic (one 32-bit subtract and compares) between the two.
// The user must write configuration through the APB-style port only while no request
// is in flight; the block itself does not enforce this.
module sensor_health_monitor (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [shm_pkg::REQ_DATA_W-1:0] req_tdata,  // read_ok, new_data, now_us[31:0], pad
   input  logic [1:0]                     req_tuser,  // command
   // result channel
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [shm_pkg::RSP_DATA_W-1:0] rsp_tdata,  // status[1:0], fresh, pad
   // configuration port
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [shm_pkg::ADDR_W-1:0]     csr_paddr,
   input  logic [31:0]                    csr_pwdata,
   output logic [31:0]                    csr_prdata,
   output logic                           csr_pready
);

   // configuration registers
   logic [shm_pkg::COUNT_W-1:0] degrade_failures_ff;
   logic [shm_pkg::COUNT_W-1:0] fail_failures_ff;
   logic [shm_pkg::COUNT_W-1:0] recover_successes_ff;
   logic [shm_pkg::COUNT_W-1:0] full_recover_successes_ff;
   logic [shm_pkg::TIME_W-1:0]  stale_degrade_time_ff;
   logic [shm_pkg::TIME_W-1:0]  stale_fail_time_ff;

   logic                 csr_write;
   shm_pkg::reg_index_type csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = shm_pkg::reg_index_type'(csr_paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         degrade_failures_ff       <= shm_pkg::RST_DEGRADE_FAILURES;
         fail_failures_ff          <= shm_pkg::RST_FAIL_FAILURES;
         recover_successes_ff      <= shm_pkg::RST_RECOVER_SUCCESSES;
         full_recover_successes_ff <= shm_pkg::RST_FULL_RECOVER_SUCCESSES;
         stale_degrade_time_ff     <= shm_pkg::RST_STALE_DEGRADE_TIME;
         stale_fail_time_ff        <= shm_pkg::RST_STALE_FAIL_TIME;
      end else if (csr_write) begin
         unique case (csr_index)
            shm_pkg::REG_DEGRADE_FAILURES:       degrade_failures_ff <= csr_pwdata[7:0];
            shm_pkg::REG_FAIL_FAILURES:          fail_failures_ff <= csr_pwdata[7:0];
            shm_pkg::REG_RECOVER_SUCCESSES:      recover_successes_ff <= csr_pwdata[7:0];
            shm_pkg::REG_FULL_RECOVER_SUCCESSES: full_recover_successes_ff <= csr_pwdata[7:0];
            shm_pkg::REG_STALE_DEGRADE_TIME:     stale_degrade_time_ff <= csr_pwdata;
            shm_pkg::REG_STALE_FAIL_TIME:        stale_fail_time_ff <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         shm_pkg::REG_DEGRADE_FAILURES:       csr_prdata = {24'd0, degrade_failures_ff};
         shm_pkg::REG_FAIL_FAILURES:          csr_prdata = {24'd0, fail_failures_ff};
         shm_pkg::REG_RECOVER_SUCCESSES:      csr_prdata = {24'd0, recover_successes_ff};
         shm_pkg::REG_FULL_RECOVER_SUCCESSES: csr_prdata = {24'd0, full_recover_successes_ff};
         shm_pkg::REG_STALE_DEGRADE_TIME:     csr_prdata = stale_degrade_time_ff;
         shm_pkg::REG_STALE_FAIL_TIME:        csr_prdata = stale_fail_time_ff;
         default:                             csr_prdata = 32'd0;
      endcase
   end

   // input register
   logic                        in_valid_ff;
   shm_pkg::command_type        in_cmd_ff;
   logic                        in_ok_ff;
   logic                        in_nd_ff;
   logic [shm_pkg::TIME_W-1:0]  in_now_ff;

   // result register
   logic                        rsp_valid_ff;
   shm_pkg::health_type         rsp_status_ff;
   logic                        rsp_fresh_ff;

   logic out_free;
   logic advance;
   logic req_accept;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;
   assign req_accept = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_cmd_ff <= shm_pkg::command_type'(req_tuser);
         in_ok_ff  <= req_tdata[0];
         in_nd_ff  <= req_tdata[1];
         in_now_ff <= req_tdata[33:2];
      end
   end

   // health state
   shm_pkg::health_type         health_ff,  health_in;
   logic [shm_pkg::COUNT_W-1:0] success_ff, success_in;
   logic [shm_pkg::COUNT_W-1:0] failure_ff, failure_in;
   logic [shm_pkg::TIME_W-1:0]  last_ff,    last_in;
   logic                        fresh_ff,   fresh_in;

   shm_pkg::health_type         h_rec;
   logic [shm_pkg::COUNT_W-1:0] s_rec;
   logic [shm_pkg::COUNT_W-1:0] f_inc;
   logic [shm_pkg::COUNT_W-1:0] s_inc;
   logic [shm_pkg::TIME_W-1:0]  age;
   logic                        stale_fail;
   logic                        stale_degrade;
   logic                        check;

   assign f_inc = shm_pkg::sat_inc(failure_ff);
   assign s_inc = shm_pkg::sat_inc(success_ff);
   assign age   = in_now_ff - last_ff;
   assign stale_fail    = (stale_fail_time_ff != '0) && (age >= stale_fail_time_ff);
   assign stale_degrade = (stale_degrade_time_ff != '0) && (age >= stale_degrade_time_ff);

   always_comb begin
      health_in  = health_ff;
      success_in = success_ff;
      failure_in = failure_ff;
      last_in    = last_ff;
      fresh_in   = fresh_ff;
      h_rec      = health_ff;
      s_rec      = success_ff;
      check      = 1'b0;

      case (in_cmd_ff)
         shm_pkg::CMD_RECORD: begin
            if (health_ff == shm_pkg::HEALTH_UNINIT) begin
               fresh_in = 1'b0;
            end else begin
               fresh_in = in_ok_ff && in_nd_ff;
               if (!in_ok_ff) begin
                  failure_in = f_inc;
                  s_rec      = '0;
                  if (health_ff == shm_pkg::HEALTH_NOMINAL) begin
                     if (f_inc >= fail_failures_ff) h_rec = shm_pkg::HEALTH_FAILED;
                     else if (f_inc >= degrade_failures_ff) h_rec = shm_pkg::HEALTH_DEGRADED;
                  end else if (health_ff == shm_pkg::HEALTH_DEGRADED) begin
                     if (f_inc >= fail_failures_ff) h_rec = shm_pkg::HEALTH_FAILED;
                  end
                  check = 1'b1;
               end else if (in_nd_ff) begin
                  // fresh sample: staleness check is skipped
                  last_in    = in_now_ff;
                  failure_in = '0;
                  s_rec      = s_inc;
                  if (health_ff == shm_pkg::HEALTH_FAILED) begin
                     if (s_inc >= recover_successes_ff) begin
                        h_rec = shm_pkg::HEALTH_DEGRADED;
                        s_rec = '0;
                     end
                  end else if (health_ff == shm_pkg::HEALTH_DEGRADED) begin
                     if (s_inc >= full_recover_successes_ff) h_rec = shm_pkg::HEALTH_NOMINAL;
                  end
               end else begin
                  failure_in = '0;
                  check      = 1'b1;
               end
            end
         end
         shm_pkg::CMD_IDLE: begin
            fresh_in = 1'b0;
            check    = (health_ff != shm_pkg::HEALTH_UNINIT);
         end
         shm_pkg::CMD_BEGIN: begin
            h_rec      = in_ok_ff ? shm_pkg::HEALTH_NOMINAL : shm_pkg::HEALTH_FAILED;
            s_rec      = '0;
            failure_in = '0;
            last_in    = in_now_ff;
            fresh_in   = 1'b0;
         end
         default: begin
            if (health_ff == shm_pkg::HEALTH_NOMINAL) begin
               h_rec = shm_pkg::HEALTH_DEGRADED;
               s_rec = '0;
            end
         end
      endcase

      health_in  = h_rec;
      success_in = s_rec;
      if (check) begin
         if (stale_fail) begin
            if (h_rec != shm_pkg::HEALTH_FAILED) begin
               health_in  = shm_pkg::HEALTH_FAILED;
               success_in = '0;
            end
         end else if (stale_degrade) begin
            if (h_rec == shm_pkg::HEALTH_NOMINAL) begin
               health_in  = shm_pkg::HEALTH_DEGRADED;
               success_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         health_ff  <= shm_pkg::HEALTH_UNINIT;
         success_ff <= '0;
         failure_ff <= '0;
         last_ff    <= '0;
         fresh_ff   <= 1'b0;
      end else if (advance) begin
         health_ff  <= health_in;
         success_ff <= success_in;
         failure_ff <= failure_in;
         last_ff    <= last_in;
         fresh_ff   <= fresh_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_status_ff <= health_in;
         rsp_fresh_ff  <= fresh_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_fresh_ff, rsp_status_ff};

   // once started, the sensor never returns to uninitialised
   a_no_uninit_return: assert property (@(posedge clock) disable iff (reset)
      (health_ff != shm_pkg::HEALTH_UNINIT) |=> (health_ff != shm_pkg::HEALTH_UNINIT))
      else $error("health returned to uninitialised");

   // a request leaving the input register lands in the result register
   a_advance_loads: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("request lost between stages");

   // never accept while the input register is full and cannot move on
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      !(req_accept && in_valid_ff && !out_free))
      else $error("input register overrun");

   // no fresh flag before tracking has begun
   a_uninit_not_fresh: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff == shm_pkg::HEALTH_UNINIT)) |-> !rsp_fresh_ff)
      else $error("fresh reported while uninitialised");

endmodule

>>> tb/testbench.sv
// Self-checking testbench for sensor_health_monitor: directed and random requests with
// random idling on both streams, APB register writes with read-back. Depends on shm_pkg.
module testbench;
   import shm_pkg::*;

   localparam int WATCHDOG_LIMIT = 3000;

   typedef struct packed {
      health_type status;
      logic       fresh;
   } health_report_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [1:0]            req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [ADDR_W-1:0]     csr_paddr = '0;
   logic [31:0]           csr_pwdata = '0;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   // predicted block state and register copies
   health_type         health_now;
   logic [COUNT_W-1:0] success_run;
   logic [COUNT_W-1:0] failure_run;
   logic [TIME_W-1:0]  sample_stamp;
   logic               fresh_bit;
   logic [COUNT_W-1:0] degrade_count;
   logic [COUNT_W-1:0] fail_count;
   logic [COUNT_W-1:0] recover_count;
   logic [COUNT_W-1:0] full_recover_count;
   logic [TIME_W-1:0]  stale_degrade;
   logic [TIME_W-1:0]  stale_fail;

   health_report_type pending_reports[$];
   health_report_type want;
   int             req_count = 0;
   int             rsp_count = 0;
   int             error_count = 0;
   int             setting_count = 0;
   int             quiet_cycles = 0;
   int             send_idle_pct = 0;
   int             recv_idle_pct = 0;
   int             stall_len = 0;
   logic [31:0]    now_track = '0;

   sensor_health_monitor u_top (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   task automatic advance_health(input command_type cmd, input logic ok, input logic nd,
                                 input logic [TIME_W-1:0] now);
      logic [TIME_W-1:0] age;
      logic              check_age;
      check_age = 1'b0;
      case (cmd)
         CMD_RECORD: begin
            if (health_now == HEALTH_UNINIT) begin
               fresh_bit = 1'b0;
            end else begin
               fresh_bit = ok & nd;
               check_age = 1'b1;
               if (!ok) begin
                  if (failure_run != COUNT_MAX) failure_run = failure_run + 1'b1;
                  success_run = '0;
                  if (health_now == HEALTH_NOMINAL) begin
                     if (failure_run >= fail_count) health_now = HEALTH_FAILED;
                     else if (failure_run >= degrade_count) health_now = HEALTH_DEGRADED;
                  end else if (health_now == HEALTH_DEGRADED) begin
                     if (failure_run >= fail_count) health_now = HEALTH_FAILED;
                  end
               end else if (nd) begin
                  sample_stamp = now;
                  if (success_run != COUNT_MAX) success_run = success_run + 1'b1;
                  failure_run = '0;
                  if (health_now == HEALTH_FAILED) begin
                     if (success_run >= recover_count) begin
                        health_now = HEALTH_DEGRADED;
                        success_run = '0;
                     end
                  end else if (health_now == HEALTH_DEGRADED) begin
                     if (success_run >= full_recover_count) health_now = HEALTH_NOMINAL;
                  end
               end else begin
                  failure_run = '0;
               end
            end
         end
         CMD_IDLE: begin
            fresh_bit = 1'b0;
            check_age = (health_now != HEALTH_UNINIT);
         end
         CMD_BEGIN: begin
            health_now = ok ? HEALTH_NOMINAL : HEALTH_FAILED;
            success_run = '0;
            failure_run = '0;
            sample_stamp = now;
            fresh_bit = 1'b0;
         end
         default: begin
            if (health_now == HEALTH_NOMINAL) begin
               health_now = HEALTH_DEGRADED;
               success_run = '0;
            end
         end
      endcase
      if (check_age && !fresh_bit) begin
         age = now - sample_stamp;
         if (stale_fail != '0 && age >= stale_fail) begin
            if (health_now != HEALTH_FAILED) begin
               health_now = HEALTH_FAILED;
               success_run = '0;
            end
         end else if (stale_degrade != '0 && age >= stale_degrade) begin
            if (health_now == HEALTH_NOMINAL) begin
               health_now = HEALTH_DEGRADED;
               success_run = '0;
            end
         end
      end
      pending_reports.push_back('{status: health_now, fresh: fresh_bit});
   endtask

   // request prediction, result checking and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet_cycles <= 0;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
         if (req_tvalid && req_tready) begin
            advance_health(command_type'(req_tuser), req_tdata[0], req_tdata[1],
                           req_tdata[33:2]);
         end
         if (rsp_tvalid && rsp_tready) begin
            rsp_count = rsp_count + 1;
            if (pending_reports.size() == 0) begin
               error_count++;
               $display("%0t: result with no request outstanding: expected none, actual %0h",
                        $time, rsp_tdata);
            end else begin
               want = pending_reports.pop_front();
               if (rsp_tdata[1:0] !== want.status) begin
                  error_count++;
                  $display("%0t: status mismatch: expected %0d, actual %0d",
                           $time, want.status, rsp_tdata[1:0]);
               end
               if (rsp_tdata[2] !== want.fresh) begin
                  error_count++;
                  $display("%0t: fresh mismatch: expected %0b, actual %0b",
                           $time, want.fresh, rsp_tdata[2]);
               end
            end
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired with %0d results outstanding",
                     $time, pending_reports.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   // result-side readiness, with an optional long hold-off
   always @(posedge clock) begin
      if (stall_len != 0) begin
         rsp_tready <= 1'b0;
         stall_len <= stall_len - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic send_request(input command_type cmd, input logic ok, input logic nd,
                               input logic [TIME_W-1:0] now);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= REQ_DATA_W'({now, nd, ok});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      req_count++;
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (rsp_count != req_count) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write_check(input reg_index_type idx, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      case (idx)
         REG_DEGRADE_FAILURES:       degrade_count = value[COUNT_W-1:0];
         REG_FAIL_FAILURES:          fail_count = value[COUNT_W-1:0];
         REG_RECOVER_SUCCESSES:      recover_count = value[COUNT_W-1:0];
         REG_FULL_RECOVER_SUCCESSES: full_recover_count = value[COUNT_W-1:0];
         REG_STALE_DEGRADE_TIME:     stale_degrade = value;
         default:                    stale_fail = value;
      endcase
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata !== value) begin
         error_count++;
         $display("%0t: register %0d read-back: expected %0h, actual %0h",
                  $time, idx, value, csr_prdata);
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic apply_settings(input logic [7:0] deg, input logic [7:0] fail,
                                 input logic [7:0] rec, input logic [7:0] full,
                                 input logic [31:0] s_deg, input logic [31:0] s_fail);
      wait_drained();
      csr_write_check(REG_DEGRADE_FAILURES, {24'd0, deg});
      csr_write_check(REG_FAIL_FAILURES, {24'd0, fail});
      csr_write_check(REG_RECOVER_SUCCESSES, {24'd0, rec});
      csr_write_check(REG_FULL_RECOVER_SUCCESSES, {24'd0, full});
      csr_write_check(REG_STALE_DEGRADE_TIME, s_deg);
      csr_write_check(REG_STALE_FAIL_TIME, s_fail);
      setting_count++;
   endtask

   task automatic test_directed_sequence();
      send_request(CMD_RECORD, 1'b1, 1'b1, 32'd7);
      send_request(CMD_IDLE, 1'b0, 1'b0, 32'd8);
      send_request(CMD_DEGRADE, 1'b1, 1'b0, 32'd9);
      send_request(CMD_BEGIN, 1'b0, 1'b0, 32'hFFFF_FFFF);
      repeat (3) send_request(CMD_RECORD, 1'b1, 1'b1, 32'd0);
      send_request(CMD_RECORD, 1'b1, 1'b0, 32'd1);
      send_request(CMD_DEGRADE, 1'b0, 1'b1, 32'd2);
      repeat (5) send_request(CMD_RECORD, 1'b0, 1'b1, 32'd3);
      send_request(CMD_BEGIN, 1'b1, 1'b1, 32'd0);
      send_request(CMD_DEGRADE, 1'b0, 1'b0, 32'd4);
      send_request(CMD_BEGIN, 1'b1, 1'b0, 32'd12345);
      repeat (3) send_request(CMD_RECORD, 1'b0, 1'b0, 32'd12346);
      send_request(CMD_IDLE, 1'b1, 1'b1, 32'hFFFF_FFFF);
   endtask

   task automatic test_staleness();
      apply_settings(8'd3, 8'd5, 8'd3, 8'd10, 32'd100, 32'd200);
      send_request(CMD_BEGIN, 1'b1, 1'b0, 32'd1000);
      send_request(CMD_RECORD, 1'b1, 1'b1, 32'd1050);
      send_request(CMD_RECORD, 1'b1, 1'b1, 32'd9000);
      send_request(CMD_IDLE, 1'b0, 1'b0, 32'd9099);
      send_request(CMD_IDLE, 1'b0, 1'b0, 32'd9100);
      send_request(CMD_RECORD, 1'b1, 1'b0, 32'd9200);
      send_request(CMD_BEGIN, 1'b1, 1'b0, 32'hFFFF_FF80);
      send_request(CMD_IDLE, 1'b0, 1'b0, 32'h0000_0060);
   endtask

   task automatic test_saturation();
      apply_settings(8'd255, 8'd255, 8'd255, 8'd255, 32'd0, 32'd0);
      send_request(CMD_BEGIN, 1'b1, 1'b1, 32'd0);
      repeat (258) send_request(CMD_RECORD, 1'b0, 1'b0, 32'd5);
   endtask

   task automatic test_random_phase(input logic [7:0] deg, input logic [7:0] fail,
                                    input logic [7:0] rec, input logic [7:0] full,
                                    input logic [31:0] s_deg, input logic [31:0] s_fail,
                                    input int items, input logic [31:0] step_max);
      int          sent;
      int          len;
      int          pick;
      command_type cmd;
      logic        ok;
      logic        nd;
      apply_settings(deg, fail, rec, full, s_deg, s_fail);
      now_track = $urandom;
      send_request(CMD_BEGIN, 1'($urandom_range(1)), 1'($urandom_range(1)), now_track);
      sent = 1;
      while (sent < items) begin
         pick = $urandom_range(99);
         len = 1;
         if (pick < 40) len = $urandom_range(8, 1);
         else if (pick < 70) len = $urandom_range(14, 1);
         else if (pick < 90) len = $urandom_range(3, 1);
         repeat (len) begin
            nd = 1'($urandom_range(1));
            ok = 1'($urandom_range(1));
            if (pick < 40) begin
               cmd = CMD_RECORD;
               ok = 1'b0;
            end else if (pick < 70) begin
               cmd = CMD_RECORD;
               ok = 1'b1;
               nd = 1'b1;
            end else if (pick < 80) begin
               cmd = CMD_RECORD;
               ok = 1'b1;
               nd = 1'b0;
            end else if (pick < 90) begin
               cmd = CMD_IDLE;
            end else if (pick < 95) begin
               cmd = CMD_DEGRADE;
            end else begin
               cmd = CMD_BEGIN;
            end
            now_track = now_track + $urandom_range(step_max, 0);
            if ($urandom_range(99) < 3) now_track = $urandom;
            send_request(cmd, ok, nd, now_track);
            sent++;
         end
      end
   endtask

   task automatic test_backpressure();
      int n;
      wait_drained();
      send_idle_pct = 0;
      stall_len <= 300;
      now_track = $urandom;
      send_request(CMD_BEGIN, 1'b1, 1'b0, now_track);
      for (n = 0; n < 40; n++) begin
         now_track = now_track + $urandom_range(20, 0);
         send_request(command_type'($urandom_range(1)), 1'($urandom_range(1)),
                      1'($urandom_range(1)), now_track);
      end
   endtask

   initial begin
      health_now         = HEALTH_UNINIT;
      success_run        = '0;
      failure_run        = '0;
      sample_stamp       = '0;
      fresh_bit          = 1'b0;
      degrade_count      = RST_DEGRADE_FAILURES;
      fail_count         = RST_FAIL_FAILURES;
      recover_count      = RST_RECOVER_SUCCESSES;
      full_recover_count = RST_FULL_RECOVER_SUCCESSES;
      stale_degrade      = RST_STALE_DEGRADE_TIME;
      stale_fail         = RST_STALE_FAIL_TIME;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 20;
      recv_idle_pct = 61;
      test_directed_sequence();
      test_staleness();
      test_saturation();
      test_random_phase(8'($urandom_range(6, 1)), 8'($urandom_range(10, 2)),
                        8'($urandom_range(5, 1)), 8'($urandom_range(12, 1)),
                        $urandom_range(2000, 100), $urandom_range(6000, 0), 40, 32'd400);
      test_random_phase(8'd0, 8'd0, 8'd0, 8'd0, 32'd0, 32'd0, 25, 32'd50);

      send_idle_pct = 61;
      recv_idle_pct = 20;
      test_random_phase(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                        $urandom, $urandom, 25, 32'hFFFF_FFFF);
      test_random_phase(8'($urandom_range(6, 1)), 8'($urandom_range(10, 2)),
                        8'($urandom_range(5, 1)), 8'($urandom_range(12, 1)),
                        $urandom_range(2000, 100), $urandom_range(6000, 2000), 40, 32'd600);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_phase(8'd255, 8'd255, 8'd255, 8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                        25, 32'hFFFF_FFFF);
      test_random_phase(8'($urandom_range(4, 0)), 8'($urandom_range(6, 0)),
                        8'($urandom_range(4, 0)), 8'($urandom_range(8, 0)),
                        $urandom_range(500, 1), $urandom_range(1500, 0), 40, 32'd200);
      test_backpressure();

      wait_drained();
      repeat (10) @(posedge clock);
      $display("Ran %0d requests under %0d register settings, with random idling on both",
               req_count, setting_count);
      $display("streams and one long result-side stall; %0d errors", error_count);
      if (error_count == 0 && pending_reports.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
